FILE: hw/rtl/fefu_pkg.sv
// ----------------------------------------------------------------------------
// Fire effect frame update unit: shared package
// Field widths, register indexes, the step record passed from the front end
// to the back end, and the 256-entry flame palette built at elaboration.
// ----------------------------------------------------------------------------
package fefu_pkg;

	// Heat field geometry.
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 256;
	localparam int MIN_SIZE   = 3;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int WCNT_W  = COL_W + 1;
	localparam int HCNT_W  = ROW_W + 1;
	localparam int ADDR_W  = ROW_W + COL_W;
	localparam int STORE_DEPTH = 2 ** ADDR_W;

	// Payload and register widths.
	localparam int SEED_W         = 8;
	localparam int HEAT_W         = 12;
	localparam int HEAT_MAX       = 4095;
	localparam int COLOR_W        = 8;
	localparam int RATIO_W        = 16;
	localparam int RATIO_FRAC     = 16;
	localparam int FRAME_WIDTH_W  = 10;
	localparam int FRAME_HEIGHT_W = 9;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;

	localparam int SUM_W  = HEAT_W + 2;
	localparam int PROD_W = SUM_W + RATIO_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATIO  = 2'd2;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 9'd200;
	localparam logic [RATIO_W-1:0]        DECAY_RATIO_RST  = 16'd16256;

	// Depth of the queue between front and back end (power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified pixel step, with all read coordinates resolved.
	typedef struct packed {
		logic               is_seed;
		logic               done;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [SEED_W-1:0]  seed;
		logic [ROW_W-1:0]   rd_row1;
		logic [ROW_W-1:0]   rd_row2;
		logic [COL_W-1:0]   rd_col_left;
		logic [COL_W-1:0]   rd_col_right;
	} step_t;

	localparam int PALETTE_SIZE = 256;
	typedef logic [PALETTE_SIZE-1:0][3*COLOR_W-1:0] palette_table_t;

	// One color channel of the HSL-to-RGB conversion, in exact integer form.
	function automatic logic [COLOR_W-1:0] hue_channel(input logic [63:0] q,
			input logic [63:0] t1, input logic [63:0] t2);
		logic [63:0] v;
		logic [63:0] scaled;
		if (q < 64'd128) begin
			v = 64'd128 * t1 + (t2 - t1) * q;
		end else if (q < 64'd384) begin
			v = 64'd128 * t2;
		end else if (q < 64'd512) begin
			v = 64'd128 * t1 + (t2 - t1) * (64'd512 - q);
		end else begin
			v = 64'd128 * t1;
		end
		scaled = (v * 64'd255) >> 23;
		return scaled[COLOR_W-1:0];
	endfunction

	// Palette entries as {red, green, blue}; evaluated only at elaboration.
	function automatic palette_table_t build_palette();
		palette_table_t tbl;
		logic [63:0]    hh;
		logic [63:0]    lum;
		logic [63:0]    t1;
		logic [63:0]    t2;
		logic [63:0]    q_blue;
		for (int p = 0; p < PALETTE_SIZE; p++) begin
			hh  = 64'(p) / 64'd3;
			lum = (64'(p) * 64'd2 > 64'd255) ? 64'd255 : 64'(p) * 64'd2;
			if (lum < 64'd128) begin
				t2 = 64'd511 * lum;
			end else begin
				t2 = 64'd256 * lum + 64'd65280 - 64'd255 * lum;
			end
			t1 = 64'd512 * lum - t2;
			q_blue = (64'd3 * hh >= 64'd256) ? 64'd3 * hh - 64'd256 : 64'd3 * hh + 64'd512;
			tbl[p] = {hue_channel(64'd3 * hh + 64'd256, t1, t2),
			          hue_channel(64'd3 * hh, t1, t2),
			          hue_channel(q_blue, t1, t2)};
		end
		return tbl;
	endfunction

	localparam palette_table_t PALETTE_ROM = build_palette();

endpackage

FILE: hw/rtl/fefu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read port with a registered output
// that only updates when its read enable is high.
// ----------------------------------------------------------------------------
module fefu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic                     rd_en_b,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_data_a <= mem_q[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

FILE: hw/rtl/fefu_front.sv
// ----------------------------------------------------------------------------
// Fire effect front end
// Accepts pixel steps, tracks the frame position and turns each item into a
// seed write or an update step with its neighbor coordinates resolved.
// ----------------------------------------------------------------------------
module fefu_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fefu_pkg::SEED_W-1:0]         seed_byte,
	input  logic [fefu_pkg::FRAME_WIDTH_W-1:0]  frame_width,
	input  logic [fefu_pkg::FRAME_HEIGHT_W-1:0] frame_height,
	input  logic                                queue_full,
	input  logic                                clearing,
	output logic                                push,
	output fefu_pkg::step_t                     push_step
);
	import fefu_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              seeding_q;

	logic [WCNT_W-1:0] w_eff;
	logic [WCNT_W-1:0] w_m1;
	logic [HCNT_W-1:0] h_eff;
	logic [HCNT_W-1:0] h_m1;
	logic              restart;
	logic [COL_W-1:0]  col_e;
	logic [ROW_W-1:0]  row_e;
	logic              seed_e;
	logic [WCNT_W-1:0] col_inc;
	logic [HCNT_W-1:0] row_inc;
	logic [HCNT_W-1:0] row_two;
	logic              last_col;
	logic              last_row;

	assign in_stall = queue_full | clearing;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		if (32'(frame_width) < 32'(MIN_SIZE)) begin
			w_eff = WCNT_W'(MIN_SIZE);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(frame_width);
		end
		if (32'(frame_height) < 32'(MIN_SIZE)) begin
			h_eff = HCNT_W'(MIN_SIZE);
		end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HCNT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HCNT_W'(frame_height);
		end
		w_m1 = w_eff - 1'b1;
		h_m1 = h_eff - 1'b1;

		// A size change can leave the position outside the active area; the
		// frame then starts over with the seed row.
		restart = ({1'b0, col_q} >= w_eff) || (!seeding_q && {1'b0, row_q} >= h_m1);
		col_e   = restart ? '0 : col_q;
		row_e   = restart ? '0 : row_q;
		seed_e  = restart | seeding_q;

		col_inc  = {1'b0, col_e} + 1'b1;
		row_inc  = {1'b0, row_e} + 1'b1;
		row_two  = {1'b0, row_e} + HCNT_W'(2);
		last_col = col_inc >= w_eff;
		last_row = row_inc >= h_m1;

		push_step.is_seed = seed_e;
		push_step.done    = ~seed_e & last_col & last_row;
		push_step.col     = col_e;
		push_step.row     = seed_e ? h_m1[ROW_W-1:0] : row_e;
		push_step.seed    = seed_byte;
		push_step.rd_row1 = (row_inc == h_eff) ? '0 : row_inc[ROW_W-1:0];
		push_step.rd_row2 = (row_two >= h_eff) ? ROW_W'(row_two - h_eff)
		                                       : row_two[ROW_W-1:0];
		push_step.rd_col_left  = (col_e == '0) ? w_m1[COL_W-1:0] : COL_W'(col_e - 1'b1);
		push_step.rd_col_right = last_col ? '0 : col_inc[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			seeding_q <= 1'b1;
		end else if (push) begin
			if (seed_e) begin
				row_q <= '0;
				if (last_col) begin
					col_q     <= '0;
					seeding_q <= 1'b0;
				end else begin
					col_q     <= col_inc[COL_W-1:0];
					seeding_q <= 1'b1;
				end
			end else if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					seeding_q <= 1'b1;
				end else begin
					row_q     <= row_inc[ROW_W-1:0];
					seeding_q <= 1'b0;
				end
			end else begin
				col_q     <= col_inc[COL_W-1:0];
				row_q     <= row_e;
				seeding_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/fefu_queue.sv
// ----------------------------------------------------------------------------
// Fire effect step queue
// A short FIFO of classified steps between the front and the back end.
// ----------------------------------------------------------------------------
module fefu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fefu_pkg::step_t push_step,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output fefu_pkg::step_t head_step
);
	import fefu_pkg::*;

	step_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_step  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/fefu_back.sv
// ----------------------------------------------------------------------------
// Fire effect back end
// Reads the four neighbors from two identical copies of the heat store,
// scales and saturates the sum (or takes the seed byte), writes the cell back and looks up its color.
// ----------------------------------------------------------------------------
module fefu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  fefu_pkg::step_t               head_step,
	output logic                          pop,
	input  logic [fefu_pkg::RATIO_W-1:0]  decay_ratio,
	output logic                          clearing,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fefu_pkg::COL_W-1:0]    pixel_column,
	output logic [fefu_pkg::ROW_W-1:0]    pixel_row,
	output logic [fefu_pkg::HEAT_W-1:0]   heat_value,
	output logic [fefu_pkg::COLOR_W-1:0]  color_red,
	output logic [fefu_pkg::COLOR_W-1:0]  color_green,
	output logic [fefu_pkg::COLOR_W-1:0]  color_blue,
	output logic                          frame_done
);
	import fefu_pkg::*;

	logic                  clear_q;
	logic [ADDR_W-1:0]     clear_addr_q;

	logic                  valid_s1;
	logic                  seed_flag_s1;
	logic                  done_s1;
	logic [COL_W-1:0]      col_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [SEED_W-1:0]     seed_s1;

	logic                  valid_s2;
	logic                  seed_flag_s2;
	logic                  done_s2;
	logic [COL_W-1:0]      col_s2;
	logic [ROW_W-1:0]      row_s2;
	logic [SEED_W-1:0]     seed_s2;
	logic [PROD_W-1:0]     prod_s2;

	logic                  out_valid_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [HEAT_W-1:0]     heat_q;
	logic [3*COLOR_W-1:0]  rgb_q;
	logic                  done_q;

	logic                  advance;
	logic                  store_wr_en;
	logic [ADDR_W-1:0]     store_wr_addr;
	logic [HEAT_W-1:0]     store_wr_data;
	logic [HEAT_W-1:0]     left_heat;
	logic [HEAT_W-1:0]     center_heat;
	logic [HEAT_W-1:0]     right_heat;
	logic [HEAT_W-1:0]     below_heat;
	logic [SUM_W-1:0]      sum;
	logic [SUM_W-1:0]      scaled;
	logic [HEAT_W-1:0]     heat_s2;

	// The whole pipe moves together; the store write trails the reads by two
	// steps, and no step depends on a cell written fewer than three steps back.
	assign advance  = ~out_valid_q | ~out_stall;
	assign pop      = advance & head_valid & ~clear_q;
	assign clearing = clear_q;

	assign store_wr_en   = clear_q | (valid_s2 & advance);
	assign store_wr_addr = clear_q ? clear_addr_q : {row_s2, col_s2};
	assign store_wr_data = clear_q ? '0 : heat_s2;

	fefu_ram #(
		.WIDTH(HEAT_W),
		.DEPTH(STORE_DEPTH)
	) u_store_left (
		.clk      (clk),
		.wr_en    (store_wr_en),
		.wr_addr  (store_wr_addr),
		.wr_data  (store_wr_data),
		.rd_en_a  (pop),
		.rd_addr_a({head_step.rd_row1, head_step.rd_col_left}),
		.rd_data_a(left_heat),
		.rd_en_b  (pop),
		.rd_addr_b({head_step.rd_row1, head_step.col}),
		.rd_data_b(center_heat)
	);

	fefu_ram #(
		.WIDTH(HEAT_W),
		.DEPTH(STORE_DEPTH)
	) u_store_right (
		.clk      (clk),
		.wr_en    (store_wr_en),
		.wr_addr  (store_wr_addr),
		.wr_data  (store_wr_data),
		.rd_en_a  (pop),
		.rd_addr_a({head_step.rd_row1, head_step.rd_col_right}),
		.rd_data_a(right_heat),
		.rd_en_b  (pop),
		.rd_addr_b({head_step.rd_row2, head_step.col}),
		.rd_data_b(below_heat)
	);

	always_comb begin
		sum = SUM_W'(left_heat) + SUM_W'(center_heat) + SUM_W'(right_heat)
		    + SUM_W'(below_heat);
		scaled = prod_s2[RATIO_FRAC +: SUM_W];
		if (seed_flag_s2) begin
			heat_s2 = HEAT_W'(seed_s2);
		end else if (32'(scaled) > 32'(HEAT_MAX)) begin
			heat_s2 = HEAT_W'(HEAT_MAX);
		end else begin
			heat_s2 = scaled[HEAT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q      <= 1'b1;
			clear_addr_q <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clear_q) begin
				clear_addr_q <= clear_addr_q + 1'b1;
				if (clear_addr_q == '1) begin
					clear_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_s1    <= pop;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seed_flag_s1 <= head_step.is_seed;
			done_s1      <= head_step.done;
			col_s1       <= head_step.col;
			row_s1       <= head_step.row;
			seed_s1      <= head_step.seed;
		end
		if (advance && valid_s1) begin
			seed_flag_s2 <= seed_flag_s1;
			done_s2      <= done_s1;
			col_s2       <= col_s1;
			row_s2       <= row_s1;
			seed_s2      <= seed_s1;
			prod_s2      <= PROD_W'(sum) * PROD_W'(decay_ratio);
		end
		if (advance && valid_s2) begin
			col_q  <= col_s2;
			row_q  <= row_s2;
			heat_q <= heat_s2;
			rgb_q  <= PALETTE_ROM[heat_s2[COLOR_W-1:0]];
			done_q <= done_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_column = col_q;
	assign pixel_row    = row_q;
	assign heat_value   = heat_q;
	assign color_red    = rgb_q[2*COLOR_W +: COLOR_W];
	assign color_green  = rgb_q[COLOR_W +: COLOR_W];
	assign color_blue   = rgb_q[0 +: COLOR_W];
	assign frame_done   = done_q;

endmodule

FILE: hw/rtl/fire_effect_frame_update_unit.sv
// ----------------------------------------------------------------------------
// Fire effect frame update unit
// Each input item is one pixel step of the fire effect. A frame first seeds
// the bottom row with the input bytes, then recomputes every other row in
// raster order. Each step returns one item: the cell, its new heat and its
// palette color, with frame_done marking the last cell of the frame.
//
// Input channel: in_valid/in_stall with seed_byte. Output channel:
// out_valid/out_stall with the pixel fields. Configuration: cfg_wr_en,
// cfg_index and cfg_data write frame_width, frame_height and decay_ratio;
// write them only while no item is in flight.
// An accepted item passes the step queue and the read, scale and output
// registers. One item per cycle is taken and returned when out_stall stays
// low. The rate comes from two copies of the heat store, each with two read
// ports, that give the four neighbor reads of a step together. Reset: the
// heat store is cleared one cell per cycle, all 131072 cells, with in_stall
// high; configuration writes are taken during that time. When out_stall is
// high the pipeline holds, a four-entry queue absorbs the items already
// accepted, and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module fire_effect_frame_update_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fefu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fefu_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fefu_pkg::SEED_W-1:0]         seed_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fefu_pkg::COL_W-1:0]          pixel_column,
	output logic [fefu_pkg::ROW_W-1:0]          pixel_row,
	output logic [fefu_pkg::HEAT_W-1:0]         heat_value,
	output logic [fefu_pkg::COLOR_W-1:0]        color_red,
	output logic [fefu_pkg::COLOR_W-1:0]        color_green,
	output logic [fefu_pkg::COLOR_W-1:0]        color_blue,
	output logic                                frame_done
);
	import fefu_pkg::*;

	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [RATIO_W-1:0]        decay_ratio_q;

	logic  push;
	step_t push_step;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	step_t head_step;
	logic  clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			decay_ratio_q  <= DECAY_RATIO_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FRAME_WIDTH_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				end
				REG_DECAY_RATIO: begin
					decay_ratio_q <= cfg_data[RATIO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fefu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seed_byte   (seed_byte),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.queue_full  (queue_full),
		.clearing    (clearing),
		.push        (push),
		.push_step   (push_step)
	);

	fefu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_step (push_step),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_step (head_step)
	);

	fefu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_step   (head_step),
		.pop         (pop),
		.decay_ratio (decay_ratio_q),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_column(pixel_column),
		.pixel_row   (pixel_row),
		.heat_value  (heat_value),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.frame_done  (frame_done)
	);

endmodule

FILE: tb/sv/tb_fire_effect_frame_update_unit.sv
// ----------------------------------------------------------------------------
// Fire effect frame update unit: self-checking testbench
// Streams seed bytes into the unit through the valid/stall input channel and
// checks every pixel that comes out against a heat-field predictor kept in
// the testbench. Frame sizes and the decay ratio change between phases,
// including clamped, masked and mid-frame settings, while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fire_effect_frame_update_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fefu_pkg::*;

	localparam int RANDOM_ITEMS   = 1870;
	localparam int WATCHDOG_LIMIT = 600000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [HEAT_W-1:0]  heat;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               done;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SEED_W-1:0]    seed_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b1;
	logic [COL_W-1:0]     pixel_column;
	logic [ROW_W-1:0]     pixel_row;
	logic [HEAT_W-1:0]    heat_value;
	logic [COLOR_W-1:0]   color_red;
	logic [COLOR_W-1:0]   color_green;
	logic [COLOR_W-1:0]   color_blue;
	logic                 frame_done;

	fire_effect_frame_update_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.seed_byte(seed_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.heat_value(heat_value),
		.color_red(color_red),
		.color_green(color_green),
		.color_blue(color_blue),
		.frame_done(frame_done)
	);

	// Predictor state: the heat field, the scan position and the registers.
	logic [HEAT_W-1:0]         heat_field [MAX_WIDTH*MAX_HEIGHT];
	int unsigned               scan_col = 0;
	int unsigned               scan_row = 0;
	bit                        seeding = 1'b1;
	logic [FRAME_WIDTH_W-1:0]  width_reg = FRAME_WIDTH_RST;
	logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;
	logic [RATIO_W-1:0]        ratio_reg = DECAY_RATIO_RST;

	logic [SEED_W-1:0] seed_pending [$];
	pixel_t            pixel_expected [$];
	bit                offered_taken = 1'b0;
	int unsigned       send_idle_pct = 33;
	int unsigned       recv_stall_pct = 82;
	int unsigned       recv_hold = 0;
	int unsigned       stuck_cycles = 0;
	int unsigned       mismatches = 0;

	// Flame palette: HSL with hue p/3 and lightness min(255, 2p), full saturation.
	function automatic logic [3*COLOR_W-1:0] flame_rgb(input int unsigned p);
		longint unsigned hue;
		longint unsigned lum;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned v;
		longint unsigned pos [3];
		logic [3*COLOR_W-1:0] rgb;
		hue = p / 3;
		lum = (2 * p > 255) ? 255 : 2 * p;
		hi = (lum < 128) ? 511 * lum : lum + 65280;
		lo = 512 * lum - hi;
		pos[0] = 3 * hue + 256;
		pos[1] = 3 * hue;
		pos[2] = (3 * hue >= 256) ? 3 * hue - 256 : 3 * hue + 512;
		for (int c = 0; c < 3; c++) begin
			if (pos[c] < 128)
				v = 128 * lo + (hi - lo) * pos[c];
			else if (pos[c] < 384)
				v = 128 * hi;
			else if (pos[c] < 512)
				v = 128 * lo + (hi - lo) * (512 - pos[c]);
			else
				v = 128 * lo;
			v = (v * 255) >> 23;
			rgb[3*COLOR_W-1-COLOR_W*c -: COLOR_W] = v[COLOR_W-1:0];
		end
		return rgb;
	endfunction

	// One pixel step of the fire: seed the bottom row, then cool the rows above.
	function automatic pixel_t advance_fire(input logic [SEED_W-1:0] seed);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		int unsigned below;
		int unsigned two_below;
		int unsigned heat;
		longint unsigned scaled;
		logic [3*COLOR_W-1:0] rgb;
		pixel_t px;
		w = width_reg;
		h = height_reg;
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < MIN_SIZE) h = MIN_SIZE;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		px.done = 1'b0;
		// A size change can leave the scan outside the field: restart the frame.
		if (scan_col >= w || (!seeding && scan_row >= h - 1)) begin
			seeding = 1'b1;
			scan_col = 0;
			scan_row = 0;
		end
		x = scan_col;
		if (seeding) begin
			y = h - 1;
			heat = seed;
			heat_field[y*MAX_WIDTH + x] = heat[HEAT_W-1:0];
			scan_col++;
			if (scan_col >= w) begin
				scan_col = 0;
				scan_row = 0;
				seeding = 1'b0;
			end
		end else begin
			y = scan_row;
			below = (y + 1) % h;
			two_below = (y + 2) % h;
			scaled = heat_field[below*MAX_WIDTH + (x + w - 1) % w];
			scaled += heat_field[below*MAX_WIDTH + x];
			scaled += heat_field[below*MAX_WIDTH + (x + 1) % w];
			scaled += heat_field[two_below*MAX_WIDTH + x];
			scaled = (scaled * ratio_reg) >> RATIO_FRAC;
			heat = (scaled > HEAT_MAX) ? HEAT_MAX : int'(scaled);
			heat_field[y*MAX_WIDTH + x] = heat[HEAT_W-1:0];
			scan_col++;
			if (scan_col >= w) begin
				scan_col = 0;
				scan_row++;
				if (scan_row >= h - 1) begin
					scan_row = 0;
					seeding = 1'b1;
					px.done = 1'b1;
				end
			end
		end
		rgb = flame_rgb(heat % 256);
		px.col = x[COL_W-1:0];
		px.row = y[ROW_W-1:0];
		px.heat = heat[HEAT_W-1:0];
		{px.red, px.green, px.blue} = rgb;
		return px;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Sender: offers the oldest pending seed and holds it until it is taken.
	always @(negedge clk) begin
		if (!in_valid || offered_taken) begin
			offered_taken = 1'b0;
			if (arst_n && seed_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				seed_byte <= seed_pending[0];
			end else begin
				in_valid <= 1'b0;
				seed_byte <= SEED_W'($urandom);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (recv_hold != 0) begin
			out_stall <= 1'b1;
			recv_hold = recv_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		bit moved;
		moved = 1'b0;
		if (in_valid && !in_stall) begin
			pixel_expected.push_back(advance_fire(seed_byte));
			void'(seed_pending.pop_front());
			offered_taken = 1'b1;
			moved = 1'b1;
		end
		if (out_valid && !out_stall) begin
			moved = 1'b1;
			if (pixel_expected.size() == 0) begin
				$display("%0t: unexpected item, column %0d row %0d heat %0d", $time,
					pixel_column, pixel_row, heat_value);
				mismatches++;
			end else begin
				want = pixel_expected.pop_front();
				check_field("pixel_column", want.col, pixel_column);
				check_field("pixel_row", want.row, pixel_row);
				check_field("heat_value", want.heat, heat_value);
				check_field("color_red", want.red, color_red);
				check_field("color_green", want.green, color_green);
				check_field("color_blue", want.blue, color_blue);
				check_field("frame_done", want.done, frame_done);
			end
		end
		stuck_cycles = moved ? 0 : stuck_cycles + 1;
	end

	// The limit outlasts the reset clearing pass, during which nothing moves.
	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_FRAME_WIDTH:  width_reg = data[FRAME_WIDTH_W-1:0];
			REG_FRAME_HEIGHT: height_reg = data[FRAME_HEIGHT_W-1:0];
			REG_DECAY_RATIO:  ratio_reg = data[RATIO_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (seed_pending.size() != 0 || pixel_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [SEED_W-1:0] random_seed();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SEED_W'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned queued;
		int unsigned phase_idx;
		int unsigned count;
		logic [FRAME_WIDTH_W-1:0]  w_val;
		logic [FRAME_HEIGHT_W-1:0] h_val;
		logic [RATIO_W-1:0]        r_val;
		foreach (heat_field[i])
			heat_field[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// One seed step under the reset sizes, taken once the clearing pass ends.
		@(posedge clk);
		seed_pending.push_back(8'h00);
		wait_idle();

		// Upper bits of the width and height writes are junk that the registers must drop.
		write_reg(REG_FRAME_WIDTH, 16'hFC03);
		write_reg(REG_FRAME_HEIGHT, 16'hFE03);
		write_reg(REG_DECAY_RATIO, 16'hFFFF);
		@(posedge clk);
		// Hot seeds at full ratio: the 3x3 field saturates by the third frame.
		for (int k = 0; k < 26; k++)
			seed_pending.push_back(8'hFF);
		wait_idle();

		queued = 0;
		phase_idx = 0;
		while (queued < RANDOM_ITEMS) begin
			if (queued < RANDOM_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_stall_pct = 82;
			end else if (queued < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 82;
				recv_stall_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			count = $urandom_range(20, 80);
			w_val = FRAME_WIDTH_W'($urandom_range(3, 10));
			h_val = FRAME_HEIGHT_W'($urandom_range(3, 7));
			if (phase_idx == 1) begin
				// Widest field, clamped from an oversize value, with more items than a row holds.
				w_val = 10'd1023;
				h_val = 9'd3;
				count = 530;
			end else if (phase_idx == 3) begin
				w_val = 10'd3;
				h_val = 9'd511;
				count = 60;
			end else if (phase_idx % 5 == 0) begin
				w_val = FRAME_WIDTH_W'($urandom_range(0, 2));
				h_val = FRAME_HEIGHT_W'($urandom_range(0, 2));
			end else if (phase_idx % 7 == 0) begin
				w_val = FRAME_WIDTH_W'($urandom_range(513, 1023));
				h_val = FRAME_HEIGHT_W'($urandom_range(257, 511));
				count = 40;
			end
			case ($urandom_range(4))
				0: r_val = '0;
				1: r_val = '1;
				2: r_val = RATIO_W'($urandom_range(15000, 17000));
				default: r_val = RATIO_W'($urandom);
			endcase
			write_reg(REG_FRAME_WIDTH, {6'($urandom), w_val});
			write_reg(REG_FRAME_HEIGHT, {7'($urandom), h_val});
			write_reg(REG_DECAY_RATIO, r_val);
			if (phase_idx == 2)
				write_reg(REG_UNUSED, 16'($urandom));
			@(posedge clk);
			for (int k = 0; k < count; k++)
				seed_pending.push_back(random_seed());
			// Back up the output while the sender keeps offering items.
			if (phase_idx == 2)
				recv_hold = 60;
			queued += count;
			phase_idx++;
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && pixel_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
